[rtl/core/bssa_pkg.sv]
package bssa_pkg;

    localparam int MAX_BLOCK_ROWS = 256;
    localparam int MAX_BLOCK_COLS = 256;

    localparam int VALUE_W = 64;
    localparam int DEST_W  = 20;
    localparam int DIM_W   = 9;
    localparam int MASK_W  = 9;
    localparam int SIZE_W  = 4;
    localparam int CNT_W   = 8;
    localparam int POS_W   = 10;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COLS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARSITY_MASK = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 4'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // One queued write: the pieces of the address product and the word itself.
    typedef struct packed {
        logic [POS_W-1:0]   rows3;
        logic [POS_W-1:0]   dcol;
        logic [POS_W-1:0]   drow;
        logic               last;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [SIZE_W-1:0] popcount9(input logic [MASK_W-1:0] m);
        logic [SIZE_W-1:0] n;
        n = '0;
        for (int k = 0; k < MASK_W; k++)
        begin
            n = n + SIZE_W'(m[k]);
        end
        return n;
    endfunction

    // Position of the n-th set bit of m, lowest first.
    function automatic logic [SIZE_W-1:0] nth_set9(input logic [MASK_W-1:0] m,
                                                   input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] seen;
        logic [SIZE_W-1:0] pos;
        logic              found;
        seen  = '0;
        pos   = '0;
        found = 1'b0;
        for (int k = 0; k < MASK_W; k++)
        begin
            if (m[k] && !found)
            begin
                if (seen == n)
                begin
                    pos   = SIZE_W'(k);
                    found = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
        return pos;
    endfunction

    // Row inside the block for a mask position.
    function automatic logic [1:0] pos_row(input logic [SIZE_W-1:0] k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // Column inside the block for a mask position.
    function automatic logic [1:0] pos_col(input logic [SIZE_W-1:0] k);
        logic [1:0] c;
        case (k)
            4'd0, 4'd1, 4'd2: c = 2'd0;
            4'd3, 4'd4, 4'd5: c = 2'd1;
            4'd6, 4'd7, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/bssa_if.sv]
interface bssa_in_if;
    logic                           valid;
    logic                           ready;
    logic [bssa_pkg::VALUE_W-1:0]   value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface bssa_out_if;
    logic                           valid;
    logic                           ready;
    logic [bssa_pkg::DEST_W-1:0]    dest_index;
    logic [bssa_pkg::VALUE_W-1:0]   value_out;
    logic                           last_write;

    modport source (output valid, output dest_index, output value_out, output last_write,
                    input ready);
    modport sink   (input valid, input dest_index, input value_out, input last_write,
                    output ready);
endinterface

[rtl/core/bssa_front.sv]
module bssa_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bssa_pkg::cfg_wr_t      cfg,
    bssa_in_if.sink                in,
    input  bssa_pkg::queue_status_t q_status,
    output logic                   push,
    output bssa_pkg::entry_t       entry
);
    import bssa_pkg::*;

    logic [DIM_W-1:0]  rows_cfg_reg, cols_cfg_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [CNT_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  col_reg, col_next;
    logic [SIZE_W-1:0] slot_reg, slot_next;

    logic [DIM_W-1:0]  rows, cols;
    logic [SIZE_W-1:0] bsize, nnz, used, k;
    logic              accept, emit, slot_wrap, row_wrap, col_wrap;
    logic [DIM_W-1:0]  row_inc, col_inc;
    logic [SIZE_W:0]   slot_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= DIM_W'(1);
            cols_cfg_reg <= DIM_W'(1);
            mask_reg     <= '1;
            size_reg     <= SIZE_W'(9);
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_BLOCK_ROWS:    rows_cfg_reg <= cfg.data[DIM_W-1:0];
                CFG_BLOCK_COLS:    cols_cfg_reg <= cfg.data[DIM_W-1:0];
                CFG_SPARSITY_MASK: mask_reg     <= cfg.data[MASK_W-1:0];
                CFG_BLOCK_SIZE:    size_reg     <= cfg.data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Zero dimensions act as one, large ones saturate at the bound.
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows = DIM_W'(1);
        else if (rows_cfg_reg > DIM_W'(MAX_BLOCK_ROWS))
            rows = DIM_W'(MAX_BLOCK_ROWS);
        else
            rows = rows_cfg_reg;

        if (cols_cfg_reg == '0)
            cols = DIM_W'(1);
        else if (cols_cfg_reg > DIM_W'(MAX_BLOCK_COLS))
            cols = DIM_W'(MAX_BLOCK_COLS);
        else
            cols = cols_cfg_reg;
    end

    assign bsize = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign nnz   = popcount9(mask_reg);
    assign used  = (nnz < bsize) ? nnz : bsize;
    assign k     = nth_set9(mask_reg, slot_reg);

    assign in.ready = !q_status.full;
    assign accept   = in.valid && in.ready;
    assign emit     = slot_reg < used;
    assign push     = accept && emit;

    assign slot_inc  = {1'b0, slot_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign slot_wrap = slot_inc >= {1'b0, bsize};
    assign row_wrap  = row_inc >= rows;
    assign col_wrap  = col_inc >= cols;

    always_comb
    begin
        entry.rows3 = (POS_W'(rows) << 1) + POS_W'(rows);
        entry.dcol  = (POS_W'(col_reg) << 1) + POS_W'(col_reg) + POS_W'(pos_col(k));
        entry.drow  = (POS_W'(row_reg) << 1) + POS_W'(row_reg) + POS_W'(pos_row(k));
        entry.last  = (slot_inc == {1'b0, used}) && (row_inc == rows) && (col_inc == cols);
        entry.value = in.value_bits;
    end

    always_comb
    begin
        slot_next = slot_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        if (accept)
        begin
            if (slot_wrap)
            begin
                slot_next = '0;
                if (row_wrap)
                begin
                    row_next = '0;
                    col_next = col_wrap ? '0 : col_inc[CNT_W-1:0];
                end
                else
                begin
                    row_next = row_inc[CNT_W-1:0];
                end
            end
            else
            begin
                slot_next = slot_inc[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

endmodule

[rtl/core/bssa_queue.sv]
module bssa_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bssa_pkg::entry_t        push_entry,
    input  logic                    pop,
    output bssa_pkg::entry_t        head,
    output bssa_pkg::queue_status_t status
);
    import bssa_pkg::*;

    entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/bssa_back.sv]
module bssa_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bssa_pkg::entry_t        head,
    input  bssa_pkg::queue_status_t q_status,
    output logic                    pop,
    bssa_out_if.source              out
);
    import bssa_pkg::*;

    logic               valid_reg;
    logic [DEST_W-1:0]  dest_reg, dest_next;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic [DEST_W-1:0]  prod;

    // The output register is refilled whenever it is empty or being taken.
    assign pop = !q_status.empty && (!valid_reg || out.ready);

    // With eight-bit block counters the index never reaches 2^20.
    assign prod      = DEST_W'(head.rows3) * DEST_W'(head.dcol);
    assign dest_next = prod + DEST_W'(head.drow);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dest_reg  <= dest_next;
            value_reg <= head.value;
            last_reg  <= head.last;
        end
    end

    assign out.valid      = valid_reg;
    assign out.dest_index = dest_reg;
    assign out.value_out  = value_reg;
    assign out.last_write = last_reg;

endmodule

[rtl/core/block_sparse_scatter_address_unit.sv]
// Block-sparse 3x3 scatter address unit.
// The in channel carries one 64-bit stored value word per handshake, blocks in
// column-major order with block_size slots each. For every slot that maps to a
// set bit of the sparsity mask the out channel delivers one word: the dense
// column-major index, the value unchanged, and last_write on the final write of
// the matrix. Padding slots are consumed and produce nothing.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce. A word
// accepted at the input passes through the queue into the output register.
// Throughput: one input word per cycle while the queue is not full; the front
// steps one slot and the back forms one index per cycle unless held by the queue or the receiver.
// A four-entry queue separates the input side from the output register, so a
// stalled receiver only blocks the input once that queue is full; the output
// holds its word until taken.
// Reset clears the block counters and the queue and loads the registers with
// one block row, one block column, a full mask and nine slots per block.
module block_sparse_scatter_address_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    bssa_in_if.sink                           in,
    bssa_out_if.source                        out,
    input  logic                              cfg_we,
    input  logic [bssa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bssa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bssa_pkg::*;

    cfg_wr_t       cfg;
    entry_t        push_entry, head;
    queue_status_t q_status;
    logic          push, pop;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    bssa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in       (in),
        .q_status (q_status),
        .push     (push),
        .entry    (push_entry)
    );

    bssa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    bssa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .out      (out)
    );

endmodule

[rtl/core/bssa_checker.sv]
module bssa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [bssa_pkg::DEST_W-1:0]    dest_index,
    input  logic [bssa_pkg::VALUE_W-1:0]   value_out,
    input  logic                           last_write
);

    // A stalled output word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(dest_index) && $stable(value_out)
                                    && $stable(last_write))
        else $error("output payload changed while stalled");

    // The input side only backs up behind a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input not ready without output stall");

    // A fresh output word follows an input word accepted earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output word without matching input");

endmodule

bind block_sparse_scatter_address_unit bssa_checker u_bssa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in.valid),
    .in_ready   (in.ready),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .dest_index (out.dest_index),
    .value_out  (out.value_out),
    .last_write (out.last_write)
);

[verif/tb_block_sparse_scatter_address_unit.sv]
`timescale 1ns / 100ps

module tb_block_sparse_scatter_address_unit;

    import bssa_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int MAX_PRINTS    = 100;
    localparam int RANDOM_TARGET = 1400;
    localparam int FINAL_TARGET  = 1750;

    typedef struct packed {
        logic [DEST_W-1:0]  dest;
        logic [VALUE_W-1:0] value;
        logic               last;
    } scatter_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bssa_in_if  in_ch ();
    bssa_out_if out_ch ();

    block_sparse_scatter_address_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in_ch),
        .out       (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the registers and the block position counters.
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  row_at;
    logic [CNT_W-1:0]  col_at;
    logic [SIZE_W-1:0] slot_at;

    scatter_write_t expected_writes[$];
    int             fault_count   = 0;
    int             words_sent    = 0;
    int             send_gap_odds = 0;
    int             take_gap_odds = 0;
    int             take_stall    = 0;
    logic           hold_output;

    task automatic report_mismatch(input string msg);
        if (fault_count < MAX_PRINTS)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        fault_count++;
    endtask

    function automatic int eff_dim(input logic [DIM_W-1:0] d, input int limit);
        if (d == 0)
        begin
            return 1;
        end
        if (d > limit)
        begin
            return limit;
        end
        return d;
    endfunction

    function automatic logic [VALUE_W-1:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    task automatic predict_scatter_write(input logic [VALUE_W-1:0] v);
        int             rows;
        int             cols;
        int             slots;
        int             used;
        int             k;
        int             p;
        int             seen;
        int             idx;
        scatter_write_t w;
        rows  = eff_dim(rows_reg, MAX_BLOCK_ROWS);
        cols  = eff_dim(cols_reg, MAX_BLOCK_COLS);
        slots = (size_reg == 0) ? 1 : size_reg;
        used  = $countones(mask_reg);
        if (slots < used)
        begin
            used = slots;
        end
        if (slot_at < used)
        begin
            // The n-th occupied slot of a block fills the n-th set mask bit.
            seen = 0;
            k    = 0;
            for (p = 0; p < MASK_W; p++)
            begin
                if (mask_reg[p])
                begin
                    if (seen == slot_at)
                    begin
                        k = p;
                    end
                    seen++;
                end
            end
            idx     = 3 * rows * (3 * col_at + k / 3) + 3 * row_at + k % 3;
            w.dest  = idx[DEST_W-1:0];
            w.value = v;
            w.last  = (slot_at + 1 == used) && (row_at + 1 == rows) && (col_at + 1 == cols);
            expected_writes.push_back(w);
        end
        if (slot_at + 1 >= slots)
        begin
            slot_at = '0;
            if (row_at + 1 >= rows)
            begin
                row_at = '0;
                if (col_at + 1 >= cols)
                begin
                    col_at = '0;
                end
                else
                begin
                    col_at++;
                end
            end
            else
            begin
                row_at++;
            end
        end
        else
        begin
            slot_at++;
        end
    endtask

    task automatic send_word(input logic [VALUE_W-1:0] v);
        int gap;
        if (send_gap_odds != 0 && $urandom_range(0, send_gap_odds - 1) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value_bits <= v;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        predict_scatter_write(v);
        words_sent++;
    endtask

    // Sends words until the position counters come back to the first slot of
    // the first block, so the stream ends on a matrix boundary.
    task automatic finish_matrix();
        do
        begin
            send_word(random_word());
        end
        while (row_at != 0 || col_at != 0 || slot_at != 0);
    endtask

    task automatic wait_idle();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (expected_writes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (expected_writes.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected writes never came out",
                                      expected_writes.size()));
            expected_writes.delete();
        end
        // Padding words make no output, so give the pipeline time to empty.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols,
                                input logic [MASK_W-1:0] mask,
                                input logic [SIZE_W-1:0] slots);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLOCK_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_BLOCK_COLS;
        cfg_data  <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= CFG_SPARSITY_MASK;
        cfg_data  <= CFG_DATA_W'(mask);
        @(posedge clk);
        cfg_index <= CFG_BLOCK_SIZE;
        cfg_data  <= CFG_DATA_W'(slots);
        @(posedge clk);
        cfg_we   <= 1'b0;
        rows_reg = rows;
        cols_reg = cols;
        mask_reg = mask;
        size_reg = slots;
    endtask

    task automatic check_write();
        scatter_write_t want;
        if (expected_writes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected write to index %0d", out_ch.dest_index));
        end
        else
        begin
            want = expected_writes.pop_front();
            if (out_ch.dest_index !== want.dest)
            begin
                report_mismatch($sformatf("dest_index expected %0d got %0d",
                                          want.dest, out_ch.dest_index));
            end
            if (out_ch.value_out !== want.value)
            begin
                report_mismatch($sformatf("value_out expected %h got %h",
                                          want.value, out_ch.value_out));
            end
            if (out_ch.last_write !== want.last)
            begin
                report_mismatch($sformatf("last_write expected %b got %b at index %0d",
                                          want.last, out_ch.last_write, want.dest));
            end
        end
    endtask

    // Receiver: checks each taken word and stalls in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                check_write();
            end
            if (hold_output)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (take_stall != 0)
            begin
                take_stall--;
                out_ch.ready <= 1'b0;
            end
            else if (take_gap_odds != 0 && $urandom_range(0, take_gap_odds - 1) == 0)
            begin
                take_stall = $urandom_range(1, 19) - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_defaults();
        // One full 3x3 block with all positions occupied.
        send_word('0);
        send_word('1);
        send_word(64'hAAAA_AAAA_AAAA_AAAA);
        send_word(64'h5555_5555_5555_5555);
        repeat (5) send_word(random_word());
        wait_idle();
    endtask

    task automatic test_special_cases();
        // Zero dimensions and zero block size all act as one.
        apply_config(9'd0, 9'd0, 9'h155, 4'd0);
        send_word(random_word());
        send_word(random_word());
        // Block size above nine: the slots past the occupied ones are padding.
        apply_config(9'd1, 9'd1, 9'h104, 4'd12);
        repeat (12) send_word(random_word());
        // Block size below the number of occupied positions.
        apply_config(9'd2, 9'd1, 9'h1FF, 4'd2);
        repeat (4) send_word(random_word());
        // Empty mask: words are consumed with no write.
        apply_config(9'd1, 9'd1, 9'h000, 4'd1);
        send_word(random_word());
        wait_idle();
    endtask

    task automatic test_dimension_extremes();
        // Row count above the bound saturates; one whole tall matrix.
        apply_config(9'd511, 9'd1, 9'h100, 4'd1);
        finish_matrix();
        // Walk to the last block column, then widen the matrix mid-stream so
        // the indices reach the top of the range.
        apply_config(9'd1, 9'd256, 9'h001, 4'd1);
        repeat (255) send_word(random_word());
        apply_config(9'd256, 9'd300, 9'h1FF, 4'd9);
        repeat (27) send_word(random_word());
        // Shrink below the current position: both counters wrap on advance.
        apply_config(9'd2, 9'd2, MASK_W'($urandom_range(1, 511)), 4'd4);
        finish_matrix();
        finish_matrix();
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        apply_config(9'd3, 9'd2, 9'h0F3, 4'd7);
        send_gap_odds = 0;
        fork
            begin
                hold_output <= 1'b1;
                repeat (60) @(posedge clk);
                hold_output <= 1'b0;
            end
            begin
                finish_matrix();
            end
        join
        send_gap_odds = 8;
        wait_idle();
    endtask

    task automatic test_random_streams(input int target);
        int  choice;
        int  odds_pick;
        logic wide;
        while (words_sent < target)
        begin
            choice = $urandom_range(0, 9);
            wide   = (choice >= 8);
            odds_pick = $urandom_range(0, 2);
            send_gap_odds = (odds_pick == 0) ? 0 : ((odds_pick == 1) ? 3 : 8);
            odds_pick = $urandom_range(0, 2);
            take_gap_odds <= (odds_pick == 0) ? 0 : ((odds_pick == 1) ? 3 : 10);
            if (wide)
            begin
                apply_config(DIM_W'($urandom_range(0, 511)), DIM_W'($urandom_range(0, 511)),
                             MASK_W'($urandom_range(0, 511)), SIZE_W'($urandom_range(0, 15)));
            end
            else
            begin
                apply_config(DIM_W'($urandom_range(0, 4)), DIM_W'($urandom_range(0, 4)),
                             MASK_W'($urandom_range(0, 511)), SIZE_W'($urandom_range(0, 15)));
            end
            // Mostly whole matrices; now and then a stream cut off mid-matrix.
            if (wide || $urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 30)) send_word(random_word());
            end
            else
            begin
                repeat ($urandom_range(1, 2)) finish_matrix();
            end
        end
        wait_idle();
    endtask

    task automatic test_streaming_no_gaps(input int target);
        send_gap_odds = 0;
        take_gap_odds <= 0;
        while (words_sent < target)
        begin
            apply_config(DIM_W'($urandom_range(1, 4)), DIM_W'($urandom_range(1, 4)),
                         MASK_W'($urandom_range(0, 511)), SIZE_W'($urandom_range(1, 15)));
            finish_matrix();
        end
        wait_idle();
    endtask

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_BLOCK_ROWS;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.value_bits <= '0;
        hold_output      <= 1'b0;
        rows_reg = 9'd1;
        cols_reg = 9'd1;
        mask_reg = 9'h1FF;
        size_reg = 4'd9;
        row_at   = '0;
        col_at   = '0;
        slot_at  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_odds = 8;
        take_gap_odds <= 10;

        test_reset_defaults();
        test_special_cases();
        test_dimension_extremes();
        test_output_backpressure();
        test_random_streams(RANDOM_TARGET);
        test_streaming_no_gaps(FINAL_TARGET);

        wait_idle();
        if (fault_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bssa_pkg.sv
rtl/core/bssa_if.sv
rtl/core/bssa_front.sv
rtl/core/bssa_queue.sv
rtl/core/bssa_back.sv
rtl/core/block_sparse_scatter_address_unit.sv
rtl/core/bssa_checker.sv
verif/tb_block_sparse_scatter_address_unit.sv
